// ----- src/mi3_pkg.sv -----
// ============================================================================
// mi3_pkg
// Shared widths, cofactor index table and pipeline types for the 3x3
// fixed-point matrix inverse.
// ============================================================================
`default_nettype none

package mi3_pkg;

    // Element format and derived widths
    localparam int W     = 32;          // element width
    localparam int F     = 16;          // fraction bits
    localparam int NE    = 9;           // elements per matrix
    localparam int PW    = 2 * W;       // element product width
    localparam int CW    = PW + 1;      // signed cofactor width
    localparam int AW    = PW;          // cofactor magnitude width
    localparam int DW    = 3 * W + 3;   // signed determinant width
    localparam int NW    = 3 * W + 3;   // numerator / divisor / remainder width
    localparam int QB    = W + 1;       // quotient bits produced by the divider
    localparam int SHIFT_W = 6;         // condition shift width
    localparam int SHW   = NW + 63;     // width of shifted determinant compare
    localparam int FS    = 8;           // front-end pipeline stages

    localparam logic [SHIFT_W-1:0] COND_SHIFT_RESET = 6'd40;

    // Saturation limits of the quotient magnitude
    localparam logic [QB-1:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
    localparam logic [QB-1:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

    // Cofactor k = el[i0]*el[i1] - el[i2]*el[i3], row-major element order
    localparam logic [3:0] COF_IDX [NE][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // One divider lane
    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [NW-1:0] rem;
        logic [QB-1:0] nlow;
        logic [QB-1:0] quo;
    } lane_t;

    // Per-item control shared by all lanes
    typedef struct packed {
        logic          valid;
        logic          sing;
        logic [NW-1:0] den;
    } div_ctl_t;

    // Finished result
    typedef struct packed {
        logic                  sing;
        logic                  sat;
        logic [NE-1:0][W-1:0]  inv;
    } res_t;

endpackage

`default_nettype wire

// ----- src/matrix_inverse_3x3.sv -----
// ============================================================================
// matrix_inverse_3x3
// 3x3 signed Q16.16 matrix inverse by adjugate and pipelined division.
// ============================================================================
// Usage:
//   Input channel: in_valid/in_stall with the nine elements m00..m22.
//   A transfer happens on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid/out_stall with inv00..inv22, singular and
//   saturated; a transfer happens with out_valid high and out_stall low.
//   One matrix enters per cycle while in_stall is low; the nine lanes of the
//   33-stage divider pipeline (one quotient bit per stage) take new matrices while earlier ones are in flight.
//   From input transfer to out_valid a matrix passes 8 front stages
//   (products, cofactors, determinant, maximum, singular test, operand
//   setup), 33 divider stages, one merge stage and the output register.
//   When the receiver stalls, one more result lands in a skid register and
//   in_stall rises as it fills; the whole pipeline then holds.
//   Reset clears all valid bits and loads condition_shift with 40.
//   Write condition_shift through cfg_wr_en/cfg_wr_data only while idle.
// ============================================================================
`default_nettype none

module matrix_inverse_3x3
    import mi3_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [SHIFT_W-1:0]  cfg_wr_data,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [W-1:0] m00,
    input  wire logic signed [W-1:0] m01,
    input  wire logic signed [W-1:0] m02,
    input  wire logic signed [W-1:0] m10,
    input  wire logic signed [W-1:0] m11,
    input  wire logic signed [W-1:0] m12,
    input  wire logic signed [W-1:0] m20,
    input  wire logic signed [W-1:0] m21,
    input  wire logic signed [W-1:0] m22,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic signed [W-1:0]      inv00,
    output logic signed [W-1:0]      inv01,
    output logic signed [W-1:0]      inv02,
    output logic signed [W-1:0]      inv10,
    output logic signed [W-1:0]      inv11,
    output logic signed [W-1:0]      inv12,
    output logic signed [W-1:0]      inv20,
    output logic signed [W-1:0]      inv21,
    output logic signed [W-1:0]      inv22,
    output logic                     singular,
    output logic                     saturated
);

    logic [SHIFT_W-1:0] cond_shift_reg;
    logic               en;
    logic signed [W-1:0] m [NE];
    div_ctl_t           ctl_s  [QB+1];
    lane_t              lane_s [QB+1][NE];
    logic               res_valid;
    res_t               res;
    logic               out_valid_reg;
    res_t               out_reg;
    logic               skid_full_reg;
    res_t               skid_reg;
    logic               push;
    logic               out_free;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_shift_reg <= COND_SHIFT_RESET;
        end
        else if (cfg_wr_en)
        begin
            cond_shift_reg <= cfg_wr_data;
        end
    end

    // Pipeline advances while the skid register is empty
    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    assign m[0] = m00;
    assign m[1] = m01;
    assign m[2] = m02;
    assign m[3] = m10;
    assign m[4] = m11;
    assign m[5] = m12;
    assign m[6] = m20;
    assign m[7] = m21;
    assign m[8] = m22;

    mi3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (in_valid),
        .m          (m),
        .cond_shift (cond_shift_reg),
        .ctl        (ctl_s[0]),
        .lane       (lane_s[0])
    );

    // Divider stages, one quotient bit each
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        mi3_div_step u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl_i  (ctl_s[s]),
            .lane_i (lane_s[s]),
            .ctl_o  (ctl_s[s+1]),
            .lane_o (lane_s[s+1])
        );
    end

    mi3_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctl       (ctl_s[QB]),
        .lane      (lane_s[QB]),
        .res_valid (res_valid),
        .res       (res)
    );

    assign push     = en && res_valid;
    assign out_free = !out_valid_reg || !out_stall;

    // Output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= skid_full_reg || push;
            skid_full_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_full_reg ? skid_reg : res;
        end
        else if (push)
        begin
            skid_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign inv00     = out_reg.inv[0];
    assign inv01     = out_reg.inv[1];
    assign inv02     = out_reg.inv[2];
    assign inv10     = out_reg.inv[3];
    assign inv11     = out_reg.inv[4];
    assign inv12     = out_reg.inv[5];
    assign inv20     = out_reg.inv[6];
    assign inv21     = out_reg.inv[7];
    assign inv22     = out_reg.inv[8];
    assign singular  = out_reg.sing;
    assign saturated = out_reg.sat;

endmodule

`default_nettype wire

// ----- src/mi3_front.sv -----
// ============================================================================
// mi3_front
// Cofactors, determinant, largest cofactor, singular test and divider
// operand setup, eight register stages.
// ============================================================================
`default_nettype none

module mi3_front
    import mi3_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic signed [W-1:0]       m [NE],
    input  wire logic [SHIFT_W-1:0]        cond_shift,
    output div_ctl_t                       ctl,
    output lane_t                          lane [NE]
);

    logic [FS-1:0] vld_reg;

    logic signed [W-1:0]  el_reg [NE];
    logic signed [PW-1:0] pa_reg [NE];
    logic signed [PW-1:0] pb_reg [NE];
    logic signed [W-1:0]  rb_reg [3];
    logic signed [CW-1:0] cof_reg [NE];
    logic signed [W-1:0]  rc_reg [3];
    logic signed [CW-1:0] pl_reg [3];
    logic signed [CW-1:0] ph_reg [3];
    logic [AW-1:0]        absd_reg [NE];
    logic [NE-1:0]        cnegd_reg;
    logic signed [DW-1:0] det_reg;
    logic [AW-1:0]        gmax_reg [3];
    logic [AW-1:0]        abse_reg [NE];
    logic [NE-1:0]        cnege_reg;
    logic [NW-1:0]        adet_reg;
    logic                 detneg_reg;
    logic                 detzero_reg;
    logic [AW-1:0]        mx_reg;
    logic [AW-1:0]        absf_reg [NE];
    logic [NE-1:0]        cnegf_reg;
    logic                 sing_g_reg;
    logic [NW-1:0]        den_g_reg;
    logic [NW-1:0]        num_g_reg [NE];
    logic [NE-1:0]        neg_g_reg;
    logic                 sing_h_reg;
    logic [NW-1:0]        den_h_reg;
    lane_t                lane_h_reg [NE];

    logic [AW-1:0]        cof_abs [NE];
    logic [AW-1:0]        gmax_next [3];
    logic [AW-1:0]        mx_next;
    logic signed [DW-1:0] det_next;
    logic signed [DW-1:0] ndet;
    logic [SHW-1:0]       lim_shifted;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FS-2:0], in_valid};
        end
    end

    // Cofactor magnitudes
    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            logic signed [CW-1:0] ng;
            ng = -cof_reg[k];
            cof_abs[k] = cof_reg[k][CW-1] ? ng[AW-1:0] : cof_reg[k][AW-1:0];
        end
    end

    // Determinant sum and group maxima
    always_comb
    begin
        det_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            det_next = det_next + (DW'(ph_reg[r]) <<< W) + DW'(pl_reg[r]);
        end
        for (int g = 0; g < 3; g++)
        begin
            gmax_next[g] = absd_reg[3*g];
            if (absd_reg[3*g+1] > gmax_next[g])
            begin
                gmax_next[g] = absd_reg[3*g+1];
            end
            if (absd_reg[3*g+2] > gmax_next[g])
            begin
                gmax_next[g] = absd_reg[3*g+2];
            end
        end
    end

    // Overall maximum and determinant magnitude
    always_comb
    begin
        mx_next = gmax_reg[0];
        if (gmax_reg[1] > mx_next)
        begin
            mx_next = gmax_reg[1];
        end
        if (gmax_reg[2] > mx_next)
        begin
            mx_next = gmax_reg[2];
        end
        ndet = -det_reg;
    end

    assign lim_shifted = SHW'(adet_reg) << cond_shift;

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Capture elements
            el_reg <= m;

            // Element products
            for (int k = 0; k < NE; k++)
            begin
                pa_reg[k] <= PW'(el_reg[COF_IDX[k][0]]) * PW'(el_reg[COF_IDX[k][1]]);
                pb_reg[k] <= PW'(el_reg[COF_IDX[k][2]]) * PW'(el_reg[COF_IDX[k][3]]);
            end
            for (int r = 0; r < 3; r++)
            begin
                rb_reg[r] <= el_reg[r];
            end

            // Cofactors
            for (int k = 0; k < NE; k++)
            begin
                cof_reg[k] <= $signed({pa_reg[k][PW-1], pa_reg[k]})
                            - $signed({pb_reg[k][PW-1], pb_reg[k]});
            end
            rc_reg <= rb_reg;

            // Determinant partial products, split cofactor halves
            for (int r = 0; r < 3; r++)
            begin
                pl_reg[r] <= CW'(rc_reg[r])
                           * CW'($signed({1'b0, cof_reg[3*r][W-1:0]}));
                ph_reg[r] <= CW'(rc_reg[r]) * CW'($signed(cof_reg[3*r][CW-1:W]));
            end
            absd_reg <= cof_abs;
            for (int k = 0; k < NE; k++)
            begin
                cnegd_reg[k] <= cof_reg[k][CW-1];
            end

            // Determinant and group maxima
            det_reg   <= det_next;
            gmax_reg  <= gmax_next;
            abse_reg  <= absd_reg;
            cnege_reg <= cnegd_reg;

            // Determinant magnitude and largest cofactor
            detneg_reg  <= det_reg[DW-1];
            detzero_reg <= (det_reg == '0);
            adet_reg    <= det_reg[DW-1] ? NW'(ndet) : NW'(det_reg);
            mx_reg      <= mx_next;
            absf_reg    <= abse_reg;
            cnegf_reg   <= cnege_reg;

            // Singular test and divider operands
            sing_g_reg <= detzero_reg || (SHW'(mx_reg) > lim_shifted);
            den_g_reg  <= adet_reg << 1;
            for (int k = 0; k < NE; k++)
            begin
                num_g_reg[k] <= (NW'(absf_reg[k]) << (2*F+1)) + adet_reg;
            end
            neg_g_reg <= cnegf_reg ^ {NE{detneg_reg}};

            // Divider lane start: top numerator bits form the first remainder
            sing_h_reg <= sing_g_reg;
            den_h_reg  <= den_g_reg;
            for (int k = 0; k < NE; k++)
            begin
                lane_h_reg[k].neg  <= neg_g_reg[k];
                lane_h_reg[k].ovf  <= NW'(num_g_reg[k][NW-1:QB]) >= den_g_reg;
                lane_h_reg[k].rem  <= NW'(num_g_reg[k][NW-1:QB]);
                lane_h_reg[k].nlow <= num_g_reg[k][QB-1:0];
                lane_h_reg[k].quo  <= '0;
            end
        end
    end

    assign ctl.valid = vld_reg[FS-1];
    assign ctl.sing  = sing_h_reg;
    assign ctl.den   = den_h_reg;
    assign lane      = lane_h_reg;

endmodule

`default_nettype wire

// ----- src/mi3_div_step.sv -----
// ============================================================================
// mi3_div_step
// One restoring-division stage for all nine lanes: one quotient bit per
// lane, shared divisor.
// ============================================================================
`default_nettype none

module mi3_div_step
    import mi3_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  div_ctl_t      ctl_i,
    input  lane_t         lane_i [NE],
    output div_ctl_t      ctl_o,
    output lane_t         lane_o [NE]
);

    logic          valid_reg;
    logic          sing_reg;
    logic [NW-1:0] den_reg;
    lane_t         lane_reg [NE];
    lane_t         lane_next [NE];

    // Shift in one numerator bit, subtract divisor when it fits
    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            logic [NW:0] t;
            logic [NW:0] d;
            logic        ge;
            t  = {lane_i[k].rem, lane_i[k].nlow[QB-1]};
            d  = {1'b0, ctl_i.den};
            ge = (t >= d);
            lane_next[k].neg  = lane_i[k].neg;
            lane_next[k].ovf  = lane_i[k].ovf;
            lane_next[k].rem  = ge ? NW'(t - d) : NW'(t);
            lane_next[k].nlow = {lane_i[k].nlow[QB-2:0], 1'b0};
            lane_next[k].quo  = {lane_i[k].quo[QB-2:0], ge};
        end
    end

    // Hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_i.valid;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= ctl_i.sing;
            den_reg  <= ctl_i.den;
            lane_reg <= lane_next;
        end
    end

    assign ctl_o.valid = valid_reg;
    assign ctl_o.sing  = sing_reg;
    assign ctl_o.den   = den_reg;
    assign lane_o      = lane_reg;

endmodule

`default_nettype wire

// ----- src/mi3_merge.sv -----
// ============================================================================
// mi3_merge
// Saturate and sign each lane quotient, merge lane flags and apply the
// singular result.
// ============================================================================
`default_nettype none

module mi3_merge
    import mi3_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  div_ctl_t      ctl,
    input  lane_t         lane [NE],
    output logic          res_valid,
    output res_t          res
);

    logic  valid_reg;
    res_t  res_reg;
    res_t  res_next;

    // Clip, sign and combine
    always_comb
    begin
        logic [NE-1:0] clip;
        for (int k = 0; k < NE; k++)
        begin
            logic [QB-1:0] lim;
            logic [W-1:0]  mag;
            lim     = lane[k].neg ? LIM_NEG : LIM_POS;
            clip[k] = lane[k].ovf || (lane[k].quo > lim);
            mag     = clip[k] ? lim[W-1:0] : lane[k].quo[W-1:0];
            res_next.inv[k] = ctl.sing ? '0 : (lane[k].neg ? W'(0) - mag : mag);
        end
        res_next.sing = ctl.sing;
        res_next.sat  = !ctl.sing && (|clip);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire
